// File: rtl/core/tagged_value_stream_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// Tagged value stream parser: assertion macros
// Shared assertion forms used by the checker of the parser unit.
// ----------------------------------------------------------------------------
`ifndef TAGGED_VALUE_STREAM_PARSER_UNIT_DEFINES_SVH
`define TAGGED_VALUE_STREAM_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TVSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TVSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define TVSP_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tvsp_pkg.sv
// ----------------------------------------------------------------------------
// Tagged value stream parser package
// Request types, result codes, character constants and parser phases.
// ----------------------------------------------------------------------------
package tvsp_pkg;

    // Request payloads.
    typedef struct packed {
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [2:0]         error_code;
    } t_out_item;

    // Result kinds.
    localparam logic [2:0] KIND_BOOL  = 3'd0;
    localparam logic [2:0] KIND_INT   = 3'd1;
    localparam logic [2:0] KIND_SBYTE = 3'd2;
    localparam logic [2:0] KIND_SEND  = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    // Error codes.
    localparam logic [2:0] ERR_BAD_TAG     = 3'd0;
    localparam logic [2:0] ERR_BAD_BOOL    = 3'd1;
    localparam logic [2:0] ERR_BAD_INT_END = 3'd2;
    localparam logic [2:0] ERR_NO_DIGITS   = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW    = 3'd4;
    localparam logic [2:0] ERR_NO_STR_END  = 3'd5;
    localparam logic [2:0] ERR_NO_LEN_TAG  = 3'd6;

    // Characters of the tagged format.
    localparam logic [7:0] CH_BOOL_TAG = 8'h62; // 'b'
    localparam logic [7:0] CH_TRUE     = 8'h54; // 'T'
    localparam logic [7:0] CH_FALSE    = 8'h46; // 'F'
    localparam logic [7:0] CH_INT_TAG  = 8'h69; // 'i'
    localparam logic [7:0] CH_MINUS    = 8'h2D; // '-'
    localparam logic [7:0] CH_END      = 8'h24; // '$'
    localparam logic [7:0] CH_STR_TAG  = 8'h73; // 's'
    localparam logic [7:0] CH_ZERO     = 8'h30; // '0'
    localparam logic [7:0] CH_NINE     = 8'h39; // '9'

    // Saturation point of the magnitude, 2^31.
    localparam logic [35:0] MAG_CAP = 36'h0_8000_0000;

    // Parser phases, one-hot.
    typedef enum logic [6:0] {
        PH_IDLE      = 7'b000_0001,
        PH_BOOL      = 7'b000_0010,
        PH_INT_FIRST = 7'b000_0100,
        PH_INT_DIGIT = 7'b000_1000,
        PH_LEN_TAG   = 7'b001_0000,
        PH_STR_BODY  = 7'b010_0000,
        PH_STR_END   = 7'b100_0000
    } t_phase;

endpackage

// File: rtl/core/tvsp_stream_if.sv
// ----------------------------------------------------------------------------
// Tagged value stream parser channel
// Valid/ready channel carrying one request payload of a given type.
// ----------------------------------------------------------------------------
interface tvsp_stream_if #(
    parameter type T = logic [7:0]
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: rtl/core/tvsp_digit_acc.sv
// ----------------------------------------------------------------------------
// Tagged value stream parser digit accumulator
// Shifts one decimal digit into the magnitude and saturates at 2^31.
// ----------------------------------------------------------------------------
module tvsp_digit_acc
    import tvsp_pkg::*;
(
    input  logic [31:0] i_magnitude,
    input  logic [3:0]  i_digit,
    output logic [31:0] o_magnitude,
    output logic        o_saturated
);

    logic [35:0] wide_mag;
    logic [35:0] sum;

    // Times ten as two shifted copies, then add the digit.
    assign wide_mag = {4'b0000, i_magnitude};
    assign sum      = (wide_mag << 3) + (wide_mag << 1) + {32'd0, i_digit};

    // Clamp anything above 2^31.
    assign o_saturated = (sum > MAG_CAP);
    assign o_magnitude = o_saturated ? MAG_CAP[31:0] : sum[31:0];

endmodule

// File: rtl/core/tagged_value_stream_parser_unit.sv
// A result appears on o_result in the cycle after the byte that causes it.
// Throughput: one byte per cycle while the result register is free or draining;
// the parser state updates through the multiply-by-ten accumulator, and one result register holds output.
// A byte is taken whenever the result register is empty or being drained.
// Reset (synchronous, active low) returns the parser to idle awaiting a tag
// and drops any pending result.
// ----------------------------------------------------------------------------
// Tagged value stream parser unit
// Parses booleans, signed integers and length-prefixed strings from a
// byte stream and reports each value, string byte or error as a result.
// ----------------------------------------------------------------------------
module tagged_value_stream_parser_unit
    import tvsp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tvsp_stream_if.sink   i_data,
    tvsp_stream_if.source o_result
);

    // Parser state.
    t_phase      r_phase,      n_phase;
    logic [31:0] r_magnitude,  n_magnitude;
    logic        r_negative,   n_negative;
    logic        r_digit_seen, n_digit_seen;
    logic        r_overflowed, n_overflowed;
    logic        r_for_len,    n_for_len;
    logic [30:0] r_remaining,  n_remaining;
    logic [30:0] r_str_len,    n_str_len;

    // Result register.
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        accept;
    logic [7:0]  c;
    logic        is_digit;
    logic [31:0] acc_mag;
    logic        acc_sat;
    logic        res_valid;
    t_out_item   res_item;
    logic        do_fail;
    logic        do_finish;
    logic [2:0]  fail_code;
    logic [30:0] len;

    // A byte is taken when the result register is free or draining.
    assign i_data.ready   = !r_out_valid || o_result.ready;
    assign accept         = i_data.valid && i_data.ready;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_item;

    assign c        = i_data.data.data_byte;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

    tvsp_digit_acc u_digit_acc (
        .i_magnitude (r_magnitude),
        .i_digit     (c[3:0]),
        .o_magnitude (acc_mag),
        .o_saturated (acc_sat)
    );

    // Clamped string length from the finished integer.
    assign len = (r_negative || (r_magnitude == 32'd0)) ? 31'd0 : r_magnitude[30:0];

    // Next state and result for the byte at the input.
    always_comb begin
        n_phase          = r_phase;
        n_magnitude      = r_magnitude;
        n_negative       = r_negative;
        n_digit_seen     = r_digit_seen;
        n_overflowed     = r_overflowed;
        n_for_len        = r_for_len;
        n_remaining      = r_remaining;
        n_str_len        = r_str_len;
        res_valid        = 1'b0;
        res_item.kind    = KIND_BOOL;
        res_item.value   = '0;
        res_item.error_code = ERR_BAD_TAG;
        do_fail          = 1'b0;
        do_finish        = 1'b0;
        fail_code        = ERR_BAD_TAG;

        unique case (r_phase)
            PH_IDLE: begin
                if (c == CH_BOOL_TAG) begin
                    n_phase = PH_BOOL;
                end else if (c == CH_INT_TAG) begin
                    n_magnitude  = '0;
                    n_negative   = 1'b0;
                    n_digit_seen = 1'b0;
                    n_overflowed = 1'b0;
                    n_for_len    = 1'b0;
                    n_phase      = PH_INT_FIRST;
                end else if (c == CH_STR_TAG) begin
                    n_phase = PH_LEN_TAG;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_TAG;
                end
            end
            PH_BOOL: begin
                if (c == CH_TRUE || c == CH_FALSE) begin
                    n_phase        = PH_IDLE;
                    res_valid      = 1'b1;
                    res_item.kind  = KIND_BOOL;
                    res_item.value = {31'd0, (c == CH_TRUE)};
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_BOOL;
                end
            end
            PH_LEN_TAG: begin
                if (c == CH_INT_TAG) begin
                    n_magnitude  = '0;
                    n_negative   = 1'b0;
                    n_digit_seen = 1'b0;
                    n_overflowed = 1'b0;
                    n_for_len    = 1'b1;
                    n_phase      = PH_INT_FIRST;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_NO_LEN_TAG;
                end
            end
            PH_INT_FIRST: begin
                if (c == CH_MINUS) begin
                    n_negative = 1'b1;
                    n_phase    = PH_INT_DIGIT;
                end else if (is_digit) begin
                    n_magnitude  = acc_mag;
                    n_overflowed = r_overflowed | acc_sat;
                    n_digit_seen = 1'b1;
                    n_phase      = PH_INT_DIGIT;
                end else if (c == CH_END) begin
                    do_finish = 1'b1;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_INT_END;
                end
            end
            PH_INT_DIGIT: begin
                if (is_digit) begin
                    n_magnitude  = acc_mag;
                    n_overflowed = r_overflowed | acc_sat;
                    n_digit_seen = 1'b1;
                end else if (c == CH_END) begin
                    do_finish = 1'b1;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_INT_END;
                end
            end
            PH_STR_BODY: begin
                n_remaining = r_remaining - 31'd1;
                if (n_remaining == 31'd0) begin
                    n_phase = PH_STR_END;
                end
                res_valid      = 1'b1;
                res_item.kind  = KIND_SBYTE;
                res_item.value = {24'd0, c};
            end
            PH_STR_END: begin
                if (c == CH_END) begin
                    n_phase        = PH_IDLE;
                    res_valid      = 1'b1;
                    res_item.kind  = KIND_SEND;
                    res_item.value = {1'b0, r_str_len};
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_NO_STR_END;
                end
            end
            default: begin
                do_fail   = 1'b1;
                fail_code = ERR_BAD_TAG;
            end
        endcase

        // Terminator seen: check the integer, then report it or start a string.
        if (do_finish) begin
            if (!r_digit_seen) begin
                do_fail   = 1'b1;
                fail_code = ERR_NO_DIGITS;
            end else if (r_overflowed || (!r_negative && r_magnitude[31])) begin
                do_fail   = 1'b1;
                fail_code = ERR_OVERFLOW;
            end else begin
                n_magnitude  = '0;
                n_negative   = 1'b0;
                n_digit_seen = 1'b0;
                n_overflowed = 1'b0;
                if (r_for_len) begin
                    n_for_len   = 1'b0;
                    n_str_len   = len;
                    n_remaining = len;
                    n_phase     = (len == 31'd0) ? PH_STR_END : PH_STR_BODY;
                end else begin
                    n_phase        = PH_IDLE;
                    res_valid      = 1'b1;
                    res_item.kind  = KIND_INT;
                    res_item.value = r_negative ? (32'sd0 - r_magnitude) : r_magnitude;
                end
            end
        end

        // Any error returns the parser to idle.
        if (do_fail) begin
            n_phase             = PH_IDLE;
            n_for_len           = 1'b0;
            n_magnitude         = '0;
            n_negative          = 1'b0;
            n_digit_seen        = 1'b0;
            n_overflowed        = 1'b0;
            res_valid           = 1'b1;
            res_item.kind       = KIND_ERR;
            res_item.value      = '0;
            res_item.error_code = fail_code;
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_magnitude  <= '0;
            r_negative   <= 1'b0;
            r_digit_seen <= 1'b0;
            r_overflowed <= 1'b0;
            r_for_len    <= 1'b0;
            r_remaining  <= '0;
            r_str_len    <= '0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_magnitude  <= n_magnitude;
            r_negative   <= n_negative;
            r_digit_seen <= n_digit_seen;
            r_overflowed <= n_overflowed;
            r_for_len    <= n_for_len;
            r_remaining  <= n_remaining;
            r_str_len    <= n_str_len;
        end
    end

    // Result register: reloaded whenever it is free or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_data.ready) begin
            r_out_valid <= accept && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out_item <= res_item;
        end
    end

endmodule

// File: rtl/core/tvsp_checker.sv
// ----------------------------------------------------------------------------
// Tagged value stream parser checker
// Port-level assertions on the parser unit, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "tagged_value_stream_parser_unit_defines.svh"

module tvsp_checker
    import tvsp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_kind,
    input logic [31:0] i_value,
    input logic [2:0]  i_error_code
);

    // A pending result is held until it is taken.
    `TVSP_ASSERT_NEXT(a_result_held, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // Reset leaves no result pending.
    `TVSP_ASSERT_NEXT_ALWAYS(a_reset_clears, !i_rst_n, !i_out_valid, "result pending after reset")

    // An error carries a zero value.
    `TVSP_ASSERT_NOW(a_err_value, i_out_valid && i_kind == KIND_ERR, i_value == 32'd0, "error with nonzero value")

    // Only errors carry an error code.
    `TVSP_ASSERT_NOW(a_code_zero, i_out_valid && i_kind != KIND_ERR, i_error_code == ERR_BAD_TAG, "error code on a value result")

    // A boolean is zero or one.
    `TVSP_ASSERT_NOW(a_bool_range, i_out_valid && i_kind == KIND_BOOL, i_value[31:1] == 31'd0, "boolean out of range")

endmodule

bind tagged_value_stream_parser_unit tvsp_checker u_tvsp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_kind       (o_result.data.kind),
    .i_value      (o_result.data.value),
    .i_error_code (o_result.data.error_code)
);

// File: dv/tb_tagged_value_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the tagged value stream parser unit
// Streams directed and random tagged text (booleans, integers, strings and
// malformed sequences) into the parser, predicts every result from the byte
// stream alone, and checks each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_tagged_value_stream_parser_unit
    import tvsp_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 12;
    localparam int RANDOM_BYTES = 2000;

    // One byte waiting to be sent; hold makes the sender wait for all results.
    typedef struct packed {
        logic       hold;
        logic [7:0] code;
    } t_tx_byte;

    logic i_clk;
    logic i_rst_n;

    tvsp_stream_if #(.T(t_in_item))  byte_ch ();
    tvsp_stream_if #(.T(t_out_item)) result_ch ();

    tagged_value_stream_parser_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (byte_ch),
        .o_result (result_ch)
    );

    // Stimulus and expectation stores.
    t_tx_byte  tx_bytes[$];
    t_out_item awaited_values[$];
    bit        hold_next;
    int        total_bytes;
    int        bytes_taken;
    logic      drained;
    int        cycles;
    int        errors;
    int        kind_seen[5];
    logic      quiet;

    // Shadow parser state.
    t_phase      prs_phase;
    logic [31:0] acc_mag;
    logic        acc_neg;
    logic        acc_digit;
    logic        acc_ovf;
    logic        len_pending;
    logic [30:0] str_left;
    logic [30:0] str_len;

    // No idling on either side while this window of bytes goes through.
    assign quiet = (bytes_taken >= 800) && (bytes_taken < 1300);

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Reset is asserted at the start of the run and then released.
    initial begin
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    // ------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------
    function automatic void clear_acc();
        acc_mag   = '0;
        acc_neg   = 1'b0;
        acc_digit = 1'b0;
        acc_ovf   = 1'b0;
    endfunction

    function automatic t_out_item parse_error(input logic [2:0] code);
        t_out_item r;
        prs_phase   = PH_IDLE;
        len_pending = 1'b0;
        clear_acc();
        r.kind       = KIND_ERR;
        r.value      = '0;
        r.error_code = code;
        return r;
    endfunction

    // Decimal accumulate with saturation at 2^31.
    function automatic void add_digit(input logic [7:0] c);
        logic [35:0] m;
        logic [7:0]  d;
        d = c - CH_ZERO;
        m = {4'd0, acc_mag} * 36'd10 + {28'd0, d};
        acc_digit = 1'b1;
        if (m > MAG_CAP) begin
            acc_ovf = 1'b1;
            m = MAG_CAP;
        end
        acc_mag = m[31:0];
    endfunction

    // Terminator of a number: report an integer or start a string body.
    function automatic bit finish_number(output t_out_item r);
        logic [31:0] len;
        r = '0;
        if (!acc_digit) begin
            r = parse_error(ERR_NO_DIGITS);
            return 1'b1;
        end
        if (acc_ovf || (!acc_neg && acc_mag > 32'h7FFF_FFFF)) begin
            r = parse_error(ERR_OVERFLOW);
            return 1'b1;
        end
        if (len_pending) begin
            // A negative length is taken as an empty string.
            len = (acc_neg || acc_mag == 32'd0) ? 32'd0 : acc_mag;
            len_pending = 1'b0;
            str_len  = len[30:0];
            str_left = len[30:0];
            clear_acc();
            prs_phase = (len == 32'd0) ? PH_STR_END : PH_STR_BODY;
            return 1'b0;
        end
        r.kind       = KIND_INT;
        r.value      = acc_neg ? (32'd0 - acc_mag) : acc_mag;
        r.error_code = '0;
        clear_acc();
        prs_phase = PH_IDLE;
        return 1'b1;
    endfunction

    // Advance the shadow parser by one byte; returns 1 when a result is due.
    function automatic bit parse_byte(input logic [7:0] c, output t_out_item r);
        bit digit;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        r = '0;
        case (prs_phase)
            PH_IDLE: begin
                if (c == CH_BOOL_TAG) begin
                    prs_phase = PH_BOOL;
                    return 1'b0;
                end
                if (c == CH_INT_TAG) begin
                    clear_acc();
                    len_pending = 1'b0;
                    prs_phase = PH_INT_FIRST;
                    return 1'b0;
                end
                if (c == CH_STR_TAG) begin
                    prs_phase = PH_LEN_TAG;
                    return 1'b0;
                end
                r = parse_error(ERR_BAD_TAG);
                return 1'b1;
            end
            PH_BOOL: begin
                if (c == CH_TRUE || c == CH_FALSE) begin
                    prs_phase = PH_IDLE;
                    r.kind  = KIND_BOOL;
                    r.value = (c == CH_TRUE) ? 32'd1 : 32'd0;
                    return 1'b1;
                end
                r = parse_error(ERR_BAD_BOOL);
                return 1'b1;
            end
            PH_LEN_TAG: begin
                if (c == CH_INT_TAG) begin
                    clear_acc();
                    len_pending = 1'b1;
                    prs_phase = PH_INT_FIRST;
                    return 1'b0;
                end
                r = parse_error(ERR_NO_LEN_TAG);
                return 1'b1;
            end
            PH_INT_FIRST: begin
                if (c == CH_MINUS) begin
                    acc_neg = 1'b1;
                    prs_phase = PH_INT_DIGIT;
                    return 1'b0;
                end
                if (digit) begin
                    add_digit(c);
                    prs_phase = PH_INT_DIGIT;
                    return 1'b0;
                end
                if (c == CH_END) begin
                    return finish_number(r);
                end
                r = parse_error(ERR_BAD_INT_END);
                return 1'b1;
            end
            PH_INT_DIGIT: begin
                if (digit) begin
                    add_digit(c);
                    return 1'b0;
                end
                if (c == CH_END) begin
                    return finish_number(r);
                end
                r = parse_error(ERR_BAD_INT_END);
                return 1'b1;
            end
            PH_STR_BODY: begin
                str_left = str_left - 31'd1;
                if (str_left == 31'd0) begin
                    prs_phase = PH_STR_END;
                end
                r.kind  = KIND_SBYTE;
                r.value = {24'd0, c};
                return 1'b1;
            end
            PH_STR_END: begin
                if (c == CH_END) begin
                    prs_phase = PH_IDLE;
                    r.kind  = KIND_SEND;
                    r.value = {1'b0, str_len};
                    return 1'b1;
                end
                r = parse_error(ERR_NO_STR_END);
                return 1'b1;
            end
            default: begin
                r = parse_error(ERR_BAD_TAG);
                return 1'b1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        t_tx_byte e;
        e.hold = hold_next;
        e.code = b;
        tx_bytes.push_back(e);
        hold_next = 1'b0;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i]);
        end
    endtask

    // Decimal digits of a random magnitude, biased toward the 32-bit limits.
    function automatic string number_text();
        longint unsigned mag;
        string           pad;
        pad = "";
        case ($urandom_range(0, 7))
            0: mag = 64'($urandom_range(0, 9));
            1: mag = 64'($urandom_range(10, 9999));
            2: mag = 64'($urandom());
            3: mag = 64'd2147483647;
            4: mag = 64'd2147483648;
            5: mag = 64'd2147483649 + 64'($urandom_range(0, 1000));
            6: mag = {$urandom(), $urandom()};
            default: mag = 64'd4294967295;
        endcase
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) pad = {pad, "0"};
        end
        return {pad, $sformatf("%0d", mag)};
    endfunction

    // ------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_sender
        t_tx_byte nxt;
        t_in_item item;
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
            byte_ch.data  <= '0;
        end else if (!byte_ch.valid || byte_ch.ready) begin
            if (tx_bytes.size() == 0 ||
                (tx_bytes[0].hold && (byte_ch.valid || !drained)) ||
                (!quiet && $urandom_range(0, 99) < IDLE_PCT)) begin
                byte_ch.valid <= 1'b0;
            end else begin
                nxt = tx_bytes.pop_front();
                item.data_byte = nxt.code;
                byte_ch.valid <= 1'b1;
                byte_ch.data  <= item;
            end
        end
    end

    // Result receiver stalls at random outside the quiet window.
    always @(posedge i_clk) begin : result_sink
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Result checking and prediction of accepted bytes
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        t_out_item got;
        t_out_item fresh;
        if (!i_rst_n) begin
            prs_phase   = PH_IDLE;
            len_pending = 1'b0;
            str_left    = '0;
            str_len     = '0;
            clear_acc();
            awaited_values.delete();
            drained     <= 1'b1;
            bytes_taken <= 0;
        end else begin
            // Compare the result first: it belongs to an earlier byte.
            if (result_ch.valid && result_ch.ready) begin
                got = result_ch.data;
                if (got.kind <= KIND_ERR) begin
                    kind_seen[got.kind]++;
                end
                if (awaited_values.size() == 0) begin
                    $error("unexpected result: kind %0d value %0d error_code %0d",
                           got.kind, got.value, got.error_code);
                    errors++;
                end else begin
                    want = awaited_values.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                        errors++;
                    end
                    if (got.value !== want.value) begin
                        $error("value: expected %0d, actual %0d", want.value, got.value);
                        errors++;
                    end
                    if (got.error_code !== want.error_code) begin
                        $error("error_code: expected %0d, actual %0d",
                               want.error_code, got.error_code);
                        errors++;
                    end
                end
            end
            if (byte_ch.valid && byte_ch.ready) begin
                if (parse_byte(byte_ch.data.data_byte, fresh)) begin
                    awaited_values.push_back(fresh);
                end
                bytes_taken <= bytes_taken + 1;
            end
            drained <= (awaited_values.size() == 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout: %0d of %0d bytes taken, %0d results outstanding",
                 bytes_taken, total_bytes, awaited_values.size());
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stream construction and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          pick;
        int          len;
        int          next_hold;
        logic [7:0]  b;
        string       digits;

        hold_next = 1'b0;

        // Directed opening: both booleans, bad letters, extreme bytes as tags,
        // numbers with no digits, a bad terminator, a missing length tag,
        // a negative length and a missing string terminator.
        push_text("bTbF");
        push_byte(CH_BOOL_TAG);
        push_byte("x");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("i$i-$i7x");
        push_text("s5");
        push_text("si-3$$");
        push_text("si1$");
        push_byte(8'hFF);
        push_byte("#");

        // The first random sequence waits until every result has come back.
        hold_next = 1'b1;
        next_hold = tx_bytes.size() + 250;

        while (tx_bytes.size() < RANDOM_BYTES) begin
            if (tx_bytes.size() >= next_hold) begin
                hold_next = 1'b1;
                next_hold = tx_bytes.size() + 250 + $urandom_range(0, 200);
            end
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                // Boolean, now and then with a wrong letter.
                push_byte(CH_BOOL_TAG);
                if ($urandom_range(0, 9) == 0) begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_TRUE || b == CH_FALSE);
                    push_byte(b);
                end else begin
                    push_byte($urandom_range(0, 1) ? CH_TRUE : CH_FALSE);
                end
            end else if (pick < 50) begin
                // Well-formed integer text; the value may still be out of range.
                push_byte(CH_INT_TAG);
                if ($urandom_range(0, 2) == 0) push_byte(CH_MINUS);
                push_text(number_text());
                push_byte(CH_END);
            end else if (pick < 75) begin
                // String with random body bytes, mostly short.
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                  : $urandom_range(0, 6);
                push_byte(CH_STR_TAG);
                push_byte(CH_INT_TAG);
                if ($urandom_range(0, 7) == 0) begin
                    push_byte(CH_MINUS);
                    push_text($sformatf("%0d", $urandom_range(0, 500)));
                    len = 0;
                end else begin
                    if ($urandom_range(0, 5) == 0) push_byte(CH_ZERO);
                    push_text($sformatf("%0d", len));
                end
                push_byte(CH_END);
                repeat (len) push_byte(8'($urandom_range(0, 255)));
                push_byte(CH_END);
            end else begin
                // Broken sequences; each ends in an error and back at idle.
                case ($urandom_range(0, 6))
                    0: begin
                        do b = 8'($urandom_range(0, 255));
                        while (b == CH_BOOL_TAG || b == CH_INT_TAG || b == CH_STR_TAG);
                        push_byte(b);
                    end
                    1: begin
                        push_byte(CH_BOOL_TAG);
                        do b = 8'($urandom_range(0, 255)); while (b == CH_TRUE || b == CH_FALSE);
                        push_byte(b);
                    end
                    2: begin
                        push_byte(CH_INT_TAG);
                        if ($urandom_range(0, 1)) push_byte(CH_MINUS);
                        if ($urandom_range(0, 3) != 0) push_text(number_text());
                        do b = 8'($urandom_range(0, 255));
                        while (b == CH_END || (b >= CH_ZERO && b <= CH_NINE));
                        push_byte(b);
                    end
                    3: begin
                        push_byte(CH_INT_TAG);
                        if ($urandom_range(0, 1)) push_byte(CH_MINUS);
                        push_byte(CH_END);
                    end
                    4: begin
                        push_byte(CH_STR_TAG);
                        do b = 8'($urandom_range(0, 255)); while (b == CH_INT_TAG);
                        push_byte(b);
                    end
                    5: begin
                        len = $urandom_range(0, 4);
                        push_byte(CH_STR_TAG);
                        push_byte(CH_INT_TAG);
                        push_text($sformatf("%0d", len));
                        push_byte(CH_END);
                        repeat (len) push_byte(8'($urandom_range(0, 255)));
                        do b = 8'($urandom_range(0, 255)); while (b == CH_END);
                        push_byte(b);
                    end
                    default: begin
                        // Bad length: no digits, out of range, or bad terminator.
                        push_byte(CH_STR_TAG);
                        push_byte(CH_INT_TAG);
                        case ($urandom_range(0, 2))
                            0: push_text("-$");
                            1: begin
                                digits = $sformatf("%0d",
                                    64'd2147483648 + 64'($urandom_range(0, 100000)));
                                push_text(digits);
                                push_byte(CH_END);
                            end
                            default: push_text("12x");
                        endcase
                    end
                endcase
            end
        end
        total_bytes = tx_bytes.size();

        // Wait until every byte is taken and every result has been checked.
        while (bytes_taken != total_bytes || !drained) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d bytes: %0d booleans, %0d integers, %0d strings",
                 bytes_taken, kind_seen[KIND_BOOL], kind_seen[KIND_INT],
                 kind_seen[KIND_SEND]);
        $display("with %0d string bytes and %0d parse errors, %0d mismatches",
                 kind_seen[KIND_SBYTE], kind_seen[KIND_ERR], errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
